@@ rtl/mcw_pkg.sv @@
package mcw_pkg;

	typedef enum logic [2:0] {
		OP_REGISTER = 3'd0,
		OP_KICK     = 3'd1,
		OP_TICK     = 3'd2,
		OP_POLL     = 3'd3,
		OP_RECORD   = 3'd4,
		OP_READ_CH  = 3'd5,
		OP_READ_LOG = 3'd6,
		OP_SET_SAFE = 3'd7
	} op_t;

	localparam logic [7:0] REASON_TIMEOUT = 8'd0;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  channel_key;
		logic [31:0] timeout;
		logic        critical;
		logic [7:0]  index;
		logic [7:0]  reason_code;
		logic [31:0] fault_code;
		logic        enable;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [4:0]  channels_used;
		logic [4:0]  log_used;
		logic        safe_flag;
		logic [4:0]  trips_now;
		logic [7:0]  item_key;
		logic [31:0] item_time;
		logic [31:0] item_timeout;
		logic        item_tripped;
		logic        item_critical;
		logic [31:0] item_count;
		logic [7:0]  item_reason;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  key;
		logic [31:0] timeout;
		logic [31:0] kick_stamp;
		logic        tripped;
		logic [31:0] failures;
		logic        critical;
	} chan_t;

	typedef struct packed {
		logic [31:0] stamp;
		logic [31:0] code;
		logic [7:0]  source;
		logic [7:0]  reason;
	} rec_t;

endpackage

@@ rtl/mcw_stream_if.sv @@
interface mcw_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/mcw_ram.sv @@
module mcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/multi_channel_watchdog_with_fault_log.sv @@
// Multi-channel watchdog with a fault log. One item is taken at a time; ready
// is high only between items, and a finished result waits in an output
// register so the next item can be accepted meanwhile. Tick, record fault, set
// safe mode and reads out of range go straight to the done state; reads in
// range pass through a read state first. Register, kick and poll walk the
// channel table through its single read port, one channel a cycle; a kick
// that finds its key stops the walk there. While the previous result still
// waits, an item holds in its done state until that result is taken. A poll
// writes one fault record per channel that trips as it walks.
// Channel and log entries are held in RAM and are not cleared at reset.
module multi_channel_watchdog_with_fault_log
	import mcw_pkg::*;
#(
	parameter int NUM_CHANNELS = 16,
	parameter int LOG_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	mcw_stream_if.sink   in_ch,
	mcw_stream_if.source out_ch
);

	localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CH_CW = $clog2(NUM_CHANNELS + 1);
	localparam int LG_AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int LG_CW = $clog2(LOG_DEPTH + 1);
	localparam int SL_W = LG_CW + 2;
	localparam int CH_W = $bits(chan_t);
	localparam int RC_W = $bits(rec_t);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_READ = 4'b0100,
		ST_DONE = 4'b1000
	} st_t;

	st_t              st_q;
	in_item_t         req_q;
	out_item_t        res_q;
	out_item_t        out_q;
	logic             out_valid_q;
	logic [31:0]      clock_q;
	logic [CH_CW-1:0] used_q;
	logic [LG_AW-1:0] head_q;
	logic [LG_CW-1:0] fill_q;
	logic             safe_q;
	logic [CH_CW-1:0] rd_idx_q;
	logic             found_q;
	logic             ev_v_s1;
	logic [CH_AW-1:0] ev_idx_s1;

	logic             accept;
	op_t              in_op;
	op_t              cur_op;
	logic             ch_idx_ok;
	logic             lg_idx_ok;
	logic             key_hit;
	logic             rd_more;
	logic             issue;
	logic             scan_end;
	logic [31:0]      elapsed;
	logic [31:0]      fail_nx;
	logic             poll_trip;
	logic             kick_wr;
	logic             reg_ok;
	logic             reg_wr;
	logic             rec_push;
	logic             out_free;
	logic             out_load;
	logic [SL_W-1:0]  slot_raw;
	logic [LG_AW-1:0] slot;
	out_item_t        res_init;
	out_item_t        res_out;

	logic             ch_we;
	logic [CH_AW-1:0] ch_waddr;
	logic [CH_AW-1:0] ch_raddr;
	chan_t            ch_wdata;
	chan_t            ch_rdata;
	rec_t             lg_wdata;
	rec_t             lg_rdata;

	assign in_ch.ready   = (st_q == ST_IDLE);
	assign out_ch.valid  = out_valid_q;
	assign out_ch.payload = out_q;

	assign accept    = in_ch.valid && in_ch.ready;
	assign in_op     = op_t'(in_ch.payload.operation);
	assign cur_op    = op_t'(req_q.operation);
	assign ch_idx_ok = in_ch.payload.index < 8'(used_q);
	assign lg_idx_ok = in_ch.payload.index < 8'(fill_q);
	assign out_free  = !out_valid_q || out_ch.ready;
	assign out_load  = (st_q == ST_DONE) && out_free;

	// oldest-first position into the ring
	always_comb begin
		slot_raw = SL_W'(head_q) + SL_W'(LOG_DEPTH) + SL_W'(in_ch.payload.index[LG_CW-1:0])
			- SL_W'(fill_q);
		if (slot_raw >= SL_W'(2 * LOG_DEPTH)) begin
			slot_raw = slot_raw - SL_W'(2 * LOG_DEPTH);
		end else if (slot_raw >= SL_W'(LOG_DEPTH)) begin
			slot_raw = slot_raw - SL_W'(LOG_DEPTH);
		end
		slot = slot_raw[LG_AW-1:0];
	end

	assign key_hit   = ev_v_s1 && (ch_rdata.key == req_q.channel_key);
	assign rd_more   = (rd_idx_q < used_q) && !(cur_op == OP_KICK && (found_q || key_hit));
	assign issue     = (st_q == ST_SCAN) && rd_more;
	assign scan_end  = (st_q == ST_SCAN) && !rd_more && !ev_v_s1;
	assign elapsed   = clock_q - ch_rdata.kick_stamp;
	assign fail_nx   = ch_rdata.failures + 32'd1;
	assign poll_trip = (st_q == ST_SCAN) && (cur_op == OP_POLL) && ev_v_s1
		&& !ch_rdata.tripped && (elapsed > ch_rdata.timeout);
	assign kick_wr   = (st_q == ST_SCAN) && (cur_op == OP_KICK) && key_hit && !found_q;
	assign reg_ok    = (req_q.timeout != 32'd0) && (used_q < CH_CW'(NUM_CHANNELS)) && !found_q;
	assign reg_wr    = scan_end && (cur_op == OP_REGISTER) && reg_ok;
	assign rec_push  = poll_trip || (accept && in_op == OP_RECORD);

	assign ch_raddr = accept ? in_ch.payload.index[CH_AW-1:0] : rd_idx_q[CH_AW-1:0];
	assign ch_we    = poll_trip || kick_wr || reg_wr;
	assign ch_waddr = reg_wr ? used_q[CH_AW-1:0] : ev_idx_s1;

	always_comb begin
		ch_wdata = ch_rdata;
		if (poll_trip) begin
			ch_wdata.tripped  = 1'b1;
			ch_wdata.failures = fail_nx;
		end
		if (kick_wr) begin
			ch_wdata.kick_stamp = clock_q;
			ch_wdata.tripped    = 1'b0;
		end
		if (reg_wr) begin
			ch_wdata.key        = req_q.channel_key;
			ch_wdata.timeout    = req_q.timeout;
			ch_wdata.kick_stamp = clock_q;
			ch_wdata.tripped    = 1'b0;
			ch_wdata.failures   = 32'd0;
			ch_wdata.critical   = req_q.critical;
		end
	end

	always_comb begin
		lg_wdata.stamp = clock_q;
		if (poll_trip) begin
			lg_wdata.code   = fail_nx;
			lg_wdata.source = ch_rdata.key;
			lg_wdata.reason = REASON_TIMEOUT;
		end else begin
			lg_wdata.code   = in_ch.payload.fault_code;
			lg_wdata.source = in_ch.payload.channel_key;
			lg_wdata.reason = in_ch.payload.reason_code;
		end
	end

	always_comb begin
		res_init    = '0;
		res_init.ok = !((in_op == OP_READ_CH && !ch_idx_ok)
			|| (in_op == OP_READ_LOG && !lg_idx_ok));
	end

	always_comb begin
		res_out               = res_q;
		res_out.channels_used = 5'(used_q);
		res_out.log_used      = 5'(fill_q);
		res_out.safe_flag     = safe_q;
	end

	mcw_ram #(.WIDTH(CH_W), .DEPTH(NUM_CHANNELS)) u_chan_ram (
		.clk   (clk),
		.we    (ch_we),
		.waddr (ch_waddr),
		.wdata (ch_wdata),
		.raddr (ch_raddr),
		.rdata (ch_rdata)
	);

	mcw_ram #(.WIDTH(RC_W), .DEPTH(LOG_DEPTH)) u_log_ram (
		.clk   (clk),
		.we    (rec_push),
		.waddr (head_q),
		.wdata (lg_wdata),
		.raddr (slot),
		.rdata (lg_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
			clock_q     <= '0;
			used_q      <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			safe_q      <= 1'b0;
			rd_idx_q    <= '0;
			found_q     <= 1'b0;
			ev_v_s1     <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (rec_push) begin
				head_q <= (head_q == LG_AW'(LOG_DEPTH - 1)) ? '0 : head_q + 1'b1;
				if (fill_q < LG_CW'(LOG_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						found_q  <= 1'b0;
						ev_v_s1  <= 1'b0;
						case (in_op)
							OP_REGISTER, OP_KICK, OP_POLL: st_q <= ST_SCAN;
							OP_TICK: begin
								clock_q <= clock_q + 32'd1;
								st_q    <= ST_DONE;
							end
							OP_READ_CH:  st_q <= ch_idx_ok ? ST_READ : ST_DONE;
							OP_READ_LOG: st_q <= lg_idx_ok ? ST_READ : ST_DONE;
							OP_SET_SAFE: begin
								safe_q <= in_ch.payload.enable;
								st_q   <= ST_DONE;
							end
							default: st_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					ev_v_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (key_hit) begin
						found_q <= 1'b1;
					end
					if (poll_trip && ch_rdata.critical) begin
						safe_q <= 1'b1;
					end
					if (reg_wr) begin
						used_q <= used_q + 1'b1;
					end
					if (scan_end) begin
						st_q <= ST_DONE;
					end
				end
				ST_READ: st_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ev_idx_s1 <= rd_idx_q[CH_AW-1:0];
		if (accept) begin
			req_q <= in_ch.payload;
			res_q <= res_init;
		end
		if (poll_trip) begin
			res_q.trips_now <= res_q.trips_now + 5'd1;
		end
		if (scan_end && cur_op == OP_REGISTER) begin
			res_q.ok <= reg_ok;
		end
		if (scan_end && cur_op == OP_KICK) begin
			res_q.ok <= found_q;
		end
		if (st_q == ST_READ) begin
			if (cur_op == OP_READ_CH) begin
				res_q.item_key      <= ch_rdata.key;
				res_q.item_time     <= ch_rdata.kick_stamp;
				res_q.item_timeout  <= ch_rdata.timeout;
				res_q.item_tripped  <= ch_rdata.tripped;
				res_q.item_critical <= ch_rdata.critical;
				res_q.item_count    <= ch_rdata.failures;
			end else begin
				res_q.item_key    <= lg_rdata.source;
				res_q.item_time   <= lg_rdata.stamp;
				res_q.item_count  <= lg_rdata.code;
				res_q.item_reason <= lg_rdata.reason;
			end
		end
		if (out_load) begin
			out_q <= res_out;
		end
	end

endmodule

@@ rtl/mcw_checker.sv @@
module mcw_props
	import mcw_pkg::*;
#(
	parameter int LOG_DEPTH = 16
) (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// result held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result dropped or changed while stalled");

	// one item in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken before the first finished");

	a_log_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (LOG_DEPTH > 31) || (out_item.log_used <= 5'(LOG_DEPTH)))
		else $error("log fill beyond ring depth");

	// refused or out-of-range items report empty entry fields
	a_refused_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.ok |-> out_item.item_key == 8'd0 && out_item.item_time == 32'd0
			&& out_item.item_timeout == 32'd0 && out_item.item_count == 32'd0
			&& out_item.item_reason == 8'd0 && !out_item.item_tripped
			&& !out_item.item_critical && out_item.trips_now == 5'd0)
		else $error("refused item carries entry data");

endmodule

bind multi_channel_watchdog_with_fault_log mcw_props #(.LOG_DEPTH(LOG_DEPTH)) u_mcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_item  (out_ch.payload)
);
